// File: rtl/core/cts_pkg.sv
// package: constants and types for the capacity trimmed sorted store
`default_nettype none
package cts_pkg;
  localparam int unsigned SizeW = 40;
  localparam int unsigned TimeW = 40;
  localparam int unsigned SumW = 46;
  localparam int unsigned CntW = 6;
  localparam int unsigned DefDepth = 16;
  localparam logic [SumW-1:0] CapReset = 46'd34359738368;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TRIM   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_EVICTED  = 2'd2,
    KIND_DONE     = 2'd3
  } kind_e;

  typedef struct packed {
    op_e              op;
    logic [SizeW-1:0] size;
    logic [TimeW-1:0] tstamp;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [SizeW-1:0] size;
    logic [TimeW-1:0] tstamp;
    logic [SumW-1:0]  sum;
    logic [CntW-1:0]  entries;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_TRIM_CHECK,
    ST_TRIM_SCAN,
    ST_TRIM_SHIFT,
    ST_EMIT
  } state_e;
endpackage
`default_nettype wire

// File: rtl/core/cts_fifo.sv
// small queue used between front, engine and result port
`default_nettype none
module cts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic do_wr, do_rd;

  assign full_o = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/cts_engine.sv
// back part: table, running total, insert and trim sequencer
`default_nettype none
module cts_engine
  import cts_pkg::*;
#(
  parameter int unsigned Depth = DefDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [SumW-1:0] cap_i,
  input  wire logic            cmd_valid_i,
  input  wire cmd_t            cmd_i,
  output logic                 cmd_take_o,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  wire logic            res_full_i
);
  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  state_e state_q, state_d;
  logic [SizeW-1:0] size_q [Depth];
  logic [TimeW-1:0] time_q [Depth];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] best_q, best_d;
  cmd_t cmd_q, cmd_d;
  res_t res_q, res_d;

  logic ins_done;
  logic [IW-1:0] idx_s;
  logic [CW-1:0] pos;
  logic do_ins, do_shift;

  assign idx_s = idx_q[IW-1:0];
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o = res_q;
  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i;

  // insert position found when scan reaches count or a time not smaller
  assign ins_done = (idx_q >= cnt_q) || !(time_q[idx_s] < cmd_q.tstamp);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    sum_d = sum_q;
    idx_d = idx_q;
    best_d = best_q;
    cmd_d = cmd_q;
    res_d = res_q;
    pos = idx_q;
    do_ins = 1'b0;
    do_shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          if (cmd_i.op == OP_TRIM) begin
            state_d = ST_TRIM_CHECK;
          end else if (cnt_q == CW'(Depth)) begin
            res_d = '{KIND_REJECTED, '0, '0, sum_q, CntW'(cnt_q), 1'b1};
            state_d = ST_EMIT;
          end else begin
            idx_d = CW'(1);
            state_d = ST_INS_SCAN;
          end
        end
      end
      ST_INS_SCAN: begin
        if (cnt_q == '0 || time_q[0] > cmd_q.tstamp) begin
          pos = '0;
          do_ins = 1'b1;
        end else if (ins_done) begin
          pos = idx_q;
          do_ins = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
        if (do_ins) begin
          cnt_d = cnt_q + 1'b1;
          sum_d = sum_q + SumW'(cmd_q.size);
          res_d = '{KIND_INSERTED, '0, '0, sum_q + SumW'(cmd_q.size),
                    CntW'(cnt_q + 1'b1), 1'b1};
          state_d = ST_EMIT;
        end
      end
      ST_TRIM_CHECK: begin
        if (sum_q > cap_i && cnt_q != '0) begin
          idx_d = CW'(1);
          best_d = '0;
          state_d = ST_TRIM_SCAN;
        end else begin
          res_d = '{KIND_DONE, '0, '0, sum_q, CntW'(cnt_q), 1'b1};
          state_d = ST_EMIT;
        end
      end
      ST_TRIM_SCAN: begin
        if (idx_q >= cnt_q) begin
          res_d = '{KIND_EVICTED, size_q[best_q], time_q[best_q],
                    sum_q - SumW'(size_q[best_q]), CntW'(cnt_q - 1'b1), 1'b0};
          sum_d = sum_q - SumW'(size_q[best_q]);
          idx_d = CW'(best_q);
          state_d = ST_TRIM_SHIFT;
        end else begin
          if (size_q[idx_s] < size_q[best_q]) best_d = idx_s;
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TRIM_SHIFT: begin
        // close the gap one slot per cycle
        if (idx_q + 1'b1 < cnt_q) begin
          do_shift = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          if (res_q.kind == KIND_EVICTED) state_d = ST_TRIM_CHECK;
          else state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (do_ins) begin
        if (CW'(i) == pos) begin
          size_q[i] <= cmd_q.size;
          time_q[i] <= cmd_q.tstamp;
        end else if (CW'(i) > pos && CW'(i) <= cnt_q && i > 0) begin
          size_q[i] <= size_q[i-1];
          time_q[i] <= time_q[i-1];
        end
      end else if (do_shift && CW'(i) == idx_q && i + 1 < Depth) begin
        size_q[i] <= size_q[i+1];
        time_q[i] <= time_q[i+1];
      end
    end
    cmd_q <= cmd_d;
    res_q <= res_d;
    idx_q <= idx_d;
    best_q <= best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/capacity_trim_sorted_store.sv
// top level: command queue, table engine and result queue
//   channel  | direction | handshake    | fields
//   command  | in        | push / full  | opcode, item_size, item_time
//   result   | out       | pop / empty  | kind, out_size, out_time, sum_now, entries_now, last
//   capacity | in        | cfg_we_i     | cfg_wdata_i
// an insert scans the stored times one slot per cycle to find its place
// each eviction runs a check, a size scan, a shift and an emit
// reset clears count, total and queues; capacity returns to its reset value
// the engine stalls only when the result queue is full
`default_nettype none
module capacity_trim_sorted_store
  import cts_pkg::*;
#(
  parameter int unsigned TableDepth = DefDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             opcode_i,
  input  wire logic [SizeW-1:0] item_size_i,
  input  wire logic [TimeW-1:0] item_time_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [1:0]            kind_o,
  output logic [SizeW-1:0]      out_size_o,
  output logic [TimeW-1:0]      out_time_o,
  output logic [SumW-1:0]       sum_now_o,
  output logic [CntW-1:0]       entries_now_o,
  output logic                  last_o,
  input  wire logic             cfg_we_i,
  input  wire logic [SumW-1:0]  cfg_wdata_i
);
  logic [SumW-1:0] cap_q;
  cmd_t cmd_in, cmd_out;
  logic cmd_empty, cmd_take, res_valid, res_full;
  res_t res_eng, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  assign cmd_in = '{op_e'(opcode_i), item_size_i, item_time_i};

  cts_fifo #(.Width($bits(cmd_t)), .Depth(2)) u_cmd_q (
    .clk_i, .rst_ni,
    .wr_i(push), .wdata_i(cmd_in), .full_o(full),
    .rd_i(cmd_take), .rdata_o(cmd_out), .empty_o(cmd_empty)
  );

  cts_engine #(.Depth(TableDepth)) u_engine (
    .clk_i, .rst_ni,
    .cap_i(cap_q),
    .cmd_valid_i(!cmd_empty), .cmd_i(cmd_out), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res_eng), .res_full_i(res_full)
  );

  cts_fifo #(.Width($bits(res_t)), .Depth(2)) u_res_q (
    .clk_i, .rst_ni,
    .wr_i(res_valid), .wdata_i(res_eng), .full_o(res_full),
    .rd_i(pop), .rdata_o(res_out), .empty_o(empty)
  );

  assign kind_o = res_out.kind;
  assign out_size_o = res_out.size;
  assign out_time_o = res_out.tstamp;
  assign sum_now_o = res_out.sum;
  assign entries_now_o = res_out.entries;
  assign last_o = res_out.last;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// testbench for the capacity trimmed sorted store: random and directed inserts and trims
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import cts_pkg::*;
;

  localparam int unsigned Depth = DefDepth;
  localparam logic [SizeW-1:0] SizeMax = '1;
  localparam logic [SumW-1:0] SumMax = '1;

  class store_scoreboard;
    logic [SizeW-1:0] sizes[$];
    logic [TimeW-1:0] stamps[$];
    logic [SumW-1:0] total;
    logic [SumW-1:0] cap;
    res_t pending[$];
    int mismatches;
    int results_seen;

    function void clear();
      sizes.delete();
      stamps.delete();
      total = '0;
      cap = CapReset;
      pending.delete();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function res_t make(kind_e k, logic [SizeW-1:0] s, logic [TimeW-1:0] t, logic l);
      res_t r;
      r.kind = k;
      r.size = s;
      r.tstamp = t;
      r.sum = total;
      r.entries = CntW'(sizes.size());
      r.last = l;
      return r;
    endfunction

    function void note_command(op_e op, logic [SizeW-1:0] s, logic [TimeW-1:0] t);
      int pos;
      int best;
      logic [SizeW-1:0] es;
      logic [TimeW-1:0] et;
      if (op == OP_INSERT) begin
        if (sizes.size() >= Depth) begin
          pending.push_back(make(KIND_REJECTED, '0, '0, 1'b1));
          return;
        end
        if (sizes.size() == 0 || stamps[0] > t) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < sizes.size() && stamps[pos] < t) pos++;
        end
        sizes.insert(pos, s);
        stamps.insert(pos, t);
        total = total + SumW'(s);
        pending.push_back(make(KIND_INSERTED, '0, '0, 1'b1));
        return;
      end
      while (total > cap && sizes.size() > 0) begin
        best = 0;
        for (int i = 1; i < sizes.size(); i++) if (sizes[i] < sizes[best]) best = i;
        es = sizes[best];
        et = stamps[best];
        sizes.delete(best);
        stamps.delete(best);
        total = total - SumW'(es);
        pending.push_back(make(KIND_EVICTED, es, et, 1'b0));
      end
      pending.push_back(make(KIND_DONE, '0, '0, 1'b1));
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic opcode = 1'b0;
  logic [SizeW-1:0] item_size = '0;
  logic [TimeW-1:0] item_time = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] kind;
  logic [SizeW-1:0] out_size;
  logic [TimeW-1:0] out_time;
  logic [SumW-1:0] sum_now;
  logic [CntW-1:0] entries_now;
  logic last;
  logic cfg_we = 1'b0;
  logic [SumW-1:0] cfg_wdata = '0;

  store_scoreboard sb = new();
  int sender_idle_pct = 20;
  int receiver_idle_pct = 20;
  int sent;

  always #5 clk = ~clk;

  capacity_trim_sorted_store uut (
    .clk_i(clk), .rst_ni(rst_n),
    .push(push), .full(full),
    .opcode_i(opcode), .item_size_i(item_size), .item_time_i(item_time),
    .empty(empty), .pop(pop),
    .kind_o(kind), .out_size_o(out_size), .out_time_o(out_time),
    .sum_now_o(sum_now), .entries_now_o(entries_now), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  always @(posedge clk) begin
    res_t got;
    if (rst_n && pop && !empty) begin
      got.kind = kind_e'(kind);
      got.size = out_size;
      got.tstamp = out_time;
      got.sum = sum_now;
      got.entries = entries_now;
      got.last = last;
      sb.check_result(got);
    end
    pop <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // push stays high after an accepted item; idling or draining lowers it
  task automatic send_command(op_e op, logic [SizeW-1:0] s, logic [TimeW-1:0] t);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    opcode <= op;
    item_size <= s;
    item_time <= t;
    do @(posedge clk); while (full);
    sb.note_command(op, s, t);
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40 * Depth) @(posedge clk);
  endtask

  task automatic set_capacity(logic [SumW-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cap = value;
  endtask

  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(5))
      0: return SizeMax;
      1: return SizeW'($urandom_range(3));
      2: return SizeW'($urandom_range(20));
      default: return SizeW'({$urandom, $urandom} & SizeMax);
    endcase
  endfunction

  function automatic logic [TimeW-1:0] rand_stamp();
    case ($urandom_range(4))
      0: return TimeW'($urandom_range(7));
      1: return '1;
      default: return TimeW'({$urandom, $urandom} & SizeMax);
    endcase
  endfunction

  initial begin
    logic [SumW-1:0] caps [5];
    sb.clear();
    sent = 0;
    caps[0] = '0;
    caps[1] = SumMax;
    caps[2] = CapReset;
    caps[3] = 46'd40;
    caps[4] = SumW'({$urandom, $urandom} & SumMax);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty trim, ties, extremes, full table, trims
    send_command(OP_TRIM, '0, '0);
    send_command(OP_INSERT, SizeMax, 40'd5);
    send_command(OP_INSERT, 40'd1, 40'd5);
    send_command(OP_INSERT, 40'd1, 40'd2);
    send_command(OP_INSERT, '0, '1);
    send_command(OP_INSERT, 40'd1, 40'd5);
    for (int i = 0; i < 12; i++) send_command(OP_INSERT, 40'd7, TimeW'(i));
    send_command(OP_INSERT, 40'd3, 40'd9);
    send_command(OP_TRIM, '0, '0);
    set_capacity(SumMax);
    send_command(OP_TRIM, SizeMax, '1);
    set_capacity('0);
    send_command(OP_TRIM, '0, '0);

    for (int phase = 0; phase < 5; phase++) begin
      set_capacity(caps[phase]);
      sender_idle_pct = (phase == 2) ? 0 : 20;
      receiver_idle_pct = (phase == 2) ? 0 : 20;
      for (int n = 0; n < 72; n++) begin
        if ($urandom_range(99) < 25) send_command(OP_TRIM, rand_size(), rand_stamp());
        else send_command(OP_INSERT, rand_size(), rand_stamp());
        if (n == 36) drain();
      end
    end
    sender_idle_pct = 20;
    receiver_idle_pct = 20;
    set_capacity('0);
    send_command(OP_TRIM, '0, '0);
    drain();

    $display("sent %0d items, checked %0d results over five capacity settings",
             sent, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS capacity_trim_sorted_store");
    end else begin
      $display("FAIL capacity_trim_sorted_store");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL capacity_trim_sorted_store");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/core/cts_pkg.sv
rtl/core/cts_fifo.sv
rtl/core/cts_engine.sv
rtl/core/capacity_trim_sorted_store.sv
verif/tb_top.sv
